// ===== src/ircv_pkg.sv =====
// ----------------------------------------------------------------------------
// ircv_pkg
// Shared types and constants for the image record CRC verifier.
// ----------------------------------------------------------------------------
package ircv_pkg;

	localparam int unsigned LIMIT_W   = 19;
	localparam int unsigned CRC_W     = 32;
	localparam int unsigned MAGIC_W   = 32;
	localparam int unsigned SIZE_W    = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 32;

	localparam int unsigned S_TDATA_W = 112;
	localparam int unsigned M_TDATA_W = 40;

	localparam logic [CRC_W-1:0]   CRC_POLY    = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0]   CRC_PRESET  = 32'hFFFF_FFFF;
	localparam logic [MAGIC_W-1:0] MAGIC_RESET = 32'hDEAD_BEEF;
	// Slot span: end of slot area minus its base address.
	localparam logic [31:0]        SLOT_SPAN   = 32'h1008_7F00 - 32'h1001_0000;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = SLOT_SPAN[LIMIT_W-1:0];

	typedef enum logic {
		OP_BEGIN = 1'b0,
		OP_BYTE  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXPECTED_MAGIC  = 1'b0,
		REG_MAX_IMAGE_BYTES = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		op_t               op;
		logic              slot;
		logic [MAGIC_W-1:0] record_magic;
		logic [SIZE_W-1:0] record_size;
		logic [CRC_W-1:0]  record_crc;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic             verdict;
		logic             checked_slot;
		logic [CRC_W-1:0] computed_crc;
	} result_t;

	typedef struct packed {
		logic [MAGIC_W-1:0] expected_magic;
		logic [LIMIT_W-1:0] max_image_bytes;
	} cfg_t;

endpackage

// ===== src/ircv_crc_byte.sv =====
// ----------------------------------------------------------------------------
// ircv_crc_byte
// Folds one byte into a reflected CRC-32, bit by bit, LSB first.
// ----------------------------------------------------------------------------
module ircv_crc_byte import ircv_pkg::*; (
	input  logic [CRC_W-1:0]  crc_in,
	input  logic [BYTE_W-1:0] data_byte,
	output logic [CRC_W-1:0]  crc_out
);

	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		crc_out = c;
	end

endmodule

// ===== src/ircv_check.sv =====
// ----------------------------------------------------------------------------
// ircv_check
// Check state and verdict logic; consumes one registered item per advance.
// ----------------------------------------------------------------------------
module ircv_check import ircv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    item_go,
	input  item_t   item,
	output logic    res_valid,
	output result_t res
);

	logic [CRC_W-1:0]   running_crc_q;
	logic [LIMIT_W-1:0] bytes_left_q;
	logic [CRC_W-1:0]   expected_crc_q;
	logic               busy_q;
	logic               slot_q;

	logic [CRC_W-1:0]   folded_crc;
	logic [CRC_W-1:0]   final_crc;
	logic               last_byte;
	logic               magic_bad;
	logic               size_zero;
	logic               size_over;

	ircv_crc_byte u_crc (
		.crc_in   (running_crc_q),
		.data_byte(item.data_byte),
		.crc_out  (folded_crc)
	);

	assign final_crc = ~folded_crc;
	assign last_byte = (bytes_left_q == {{(LIMIT_W-1){1'b0}}, 1'b1});
	assign magic_bad = (item.record_magic != cfg.expected_magic);
	assign size_zero = (item.record_size == '0);
	assign size_over = (item.record_size >
		{{(SIZE_W-LIMIT_W){1'b0}}, cfg.max_image_bytes});

	always_comb begin
		res_valid        = 1'b0;
		res.verdict      = 1'b0;
		res.checked_slot = item.slot;
		res.computed_crc = '0;
		case (item.op)
			OP_BEGIN: begin
				res_valid        = item_go && (magic_bad || size_zero || size_over);
				res.verdict      = magic_bad || !size_zero;
				res.checked_slot = item.slot;
			end
			OP_BYTE: begin
				res_valid        = item_go && busy_q && last_byte;
				res.verdict      = (final_crc != expected_crc_q);
				res.checked_slot = slot_q;
				res.computed_crc = final_crc;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q  <= CRC_PRESET;
			bytes_left_q   <= '0;
			expected_crc_q <= '0;
			busy_q         <= 1'b0;
			slot_q         <= 1'b0;
		end else if (item_go) begin
			case (item.op)
				OP_BEGIN: begin
					slot_q        <= item.slot;
					running_crc_q <= CRC_PRESET;
					if (magic_bad || size_zero || size_over) begin
						busy_q       <= 1'b0;
						bytes_left_q <= '0;
					end else begin
						busy_q         <= 1'b1;
						bytes_left_q   <= item.record_size[LIMIT_W-1:0];
						expected_crc_q <= item.record_crc;
					end
				end
				OP_BYTE: begin
					if (busy_q) begin
						running_crc_q <= folded_crc;
						bytes_left_q  <= bytes_left_q - 1'b1;
						if (last_byte) begin
							busy_q <= 1'b0;
						end
					end
				end
				default: begin
					busy_q <= busy_q;
				end
			endcase
		end
	end

	// A running check always has bytes still to come.
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (bytes_left_q != '0))
		else $error("busy with zero bytes left");

	// A byte item only finishes a check that was running.
	a_byte_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && item.op == OP_BYTE) |-> busy_q)
		else $error("byte result while idle");

endmodule

// ===== src/ircv_out_buf.sv =====
// ----------------------------------------------------------------------------
// ircv_out_buf
// Output register with one skid entry toward the result stream.
// ----------------------------------------------------------------------------
module ircv_out_buf import ircv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_res,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop       = out_v_q && out_ready;
	assign space     = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || pop) begin
				out_v_q  <= skid_v_q || push;
				skid_v_q <= 1'b0;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_q <= skid_v_q ? skid_q : push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	// The skid entry is only used behind a held output word.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry without output word");

	// No push into a full buffer.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space)
		else $error("push while buffer full");

endmodule

// ===== src/image_record_crc_verifier_core.sv =====
// ----------------------------------------------------------------------------
// image_record_crc_verifier_core
// Firmware slot check against its tail record, CRC-32 over streamed bytes.
// ----------------------------------------------------------------------------
// A begin word (tuser = 0) carries the slot and the record's magic, size and
// stored CRC. A wrong magic or a size above max_image_bytes gives an error
// word at once, a size of zero gives a valid word at once (legacy image);
// computed_crc is 0 in those cases. Otherwise the next size byte words
// (tuser = 1) are folded into a reflected CRC-32 (poly 0xEDB88320, preset
// and final inversion all ones) and one result word follows the last byte.
// Byte words with no check running are dropped; a begin during a check
// abandons it silently. Timing: one input word per clock while the output
// side has room. Each word is held in the input register, is folded by the
// byte-wide CRC step, and any result word lands in the output register,
// from which it is presented on the master side. The output register plus
// one skid entry keeps input flowing while a result waits for m_tready.
// Write config only while idle.
// ----------------------------------------------------------------------------
module image_record_crc_verifier_core import ircv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// slave side
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [0] slot, [32:1] record_magic, [64:33] record_size,
	// [96:65] record_crc, [104:97] data_byte, [111:105] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [0] op
	input  logic [0:0]           s_tuser,
	// master side
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [0] verdict, [1] checked_slot, [33:2] computed_crc, [39:34] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	// config write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    go_s1;
	logic    buf_space;
	logic    res_valid;
	result_t res;
	result_t out_res;
	logic    s_fire;

	// Config registers: plain writes, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_magic  <= MAGIC_RESET;
			cfg_q.max_image_bytes <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPECTED_MAGIC:  cfg_q.expected_magic  <= cfg_data[MAGIC_W-1:0];
				REG_MAX_IMAGE_BYTES: cfg_q.max_image_bytes <= cfg_data[LIMIT_W-1:0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	// Input stage: advance whenever the output side has room.
	assign go_s1    = valid_s1 && buf_space;
	assign s_tready = !valid_s1 || buf_space;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload: unpack the word, low field first.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1.op           <= op_t'(s_tuser[0]);
			item_s1.slot         <= s_tdata[0];
			item_s1.record_magic <= s_tdata[32:1];
			item_s1.record_size  <= s_tdata[64:33];
			item_s1.record_crc   <= s_tdata[96:65];
			item_s1.data_byte    <= s_tdata[104:97];
		end
	end

	// Verdict logic and check state.
	ircv_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.item_go  (go_s1),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// Result register with skid.
	ircv_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_res (res),
		.space    (buf_space),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = {{(M_TDATA_W-CRC_W-2){1'b0}}, out_res.computed_crc,
		out_res.checked_slot, out_res.verdict};

	// Input only stalls behind a result the sink is holding off.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// Verdicts given at begin carry no computed CRC.
	a_begin_crc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && item_s1.op == OP_BEGIN) |-> (res.computed_crc == '0))
		else $error("begin verdict with nonzero CRC");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the image record CRC verifier core.
// ----------------------------------------------------------------------------
// Drives begin and byte words into the slave stream, mirrors the verdict
// logic and the reflected CRC-32 in a local predictor, and compares every
// result word on the master stream against the oldest predicted verdict.
// Test tasks run in turn: directed corner cases at reset settings, register
// extremes, a long receiver hold-off that backs up the input, randomized
// image checks under changing settings, and one image exactly at the limit.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ircv_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// [0] slot, [32:1] record_magic, [64:33] record_size,
	// [96:65] record_crc, [104:97] data_byte, [111:105] zero
	logic [S_TDATA_W-1:0] s_tdata;
	// [0] op
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// [0] verdict, [1] checked_slot, [33:2] computed_crc, [39:34] zero
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// Predictor copy of the registers and of the check in progress.
	logic [MAGIC_W-1:0]   magic_cfg;
	logic [LIMIT_W-1:0]   limit_cfg;
	logic [CRC_W-1:0]     crc_acc;
	logic [LIMIT_W-1:0]   bytes_to_go;
	logic [CRC_W-1:0]     stored_crc;
	bit                   check_open;
	logic                 slot_held;

	// Verdicts predicted but not yet seen on the master stream, oldest first.
	result_t              pending_verdicts[$];
	int unsigned          error_count;

	// Idling switches for both streams, and the request for a long hold-off.
	bit                   tx_idling;
	bit                   rx_idling;
	bit                   hold_req;

	image_record_crc_verifier_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// One byte step of the reflected CRC-32, LSB first.
	function automatic logic [CRC_W-1:0] crc_fold(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] r;
		r = c ^ {24'd0, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	// Advance the predictor by one accepted word and queue any verdict it causes.
	task automatic predict_word(input item_t it);
		result_t r;
		if (it.op == OP_BEGIN) begin
			// A begin always drops whatever check was running.
			check_open  = 1'b0;
			slot_held   = it.slot;
			crc_acc     = CRC_PRESET;
			bytes_to_go = '0;
			r.checked_slot = it.slot;
			r.computed_crc = '0;
			if (it.record_magic != magic_cfg) begin
				r.verdict = 1'b1;
				pending_verdicts.push_back(r);
			end else if (it.record_size == 0) begin
				// Legacy image: nothing stored, accept as is.
				r.verdict = 1'b0;
				pending_verdicts.push_back(r);
			end else if (it.record_size > {13'd0, limit_cfg}) begin
				// Full 32-bit count against the limit.
				r.verdict = 1'b1;
				pending_verdicts.push_back(r);
			end else begin
				bytes_to_go = it.record_size[LIMIT_W-1:0];
				stored_crc  = it.record_crc;
				check_open  = 1'b1;
			end
		end else if (check_open) begin
			crc_acc     = crc_fold(crc_acc, it.data_byte);
			bytes_to_go = bytes_to_go - 1'b1;
			if (bytes_to_go == 0) begin
				check_open     = 1'b0;
				r.computed_crc = ~crc_acc;
				r.checked_slot = slot_held;
				r.verdict      = (~crc_acc != stored_crc);
				pending_verdicts.push_back(r);
			end
		end
	endtask

	// Random content in every field; callers override what matters.
	function automatic item_t random_word(op_t op);
		item_t it;
		it.op           = op;
		it.slot         = 1'($urandom);
		it.record_magic = $urandom;
		it.record_size  = $urandom;
		it.record_crc   = $urandom;
		it.data_byte    = 8'($urandom);
		return it;
	endfunction

	// Offer one word, hold it until taken, then maybe drop valid for a burst.
	// Ready is sampled at the falling edge, where it is stable until the next
	// rising edge, so acceptance never depends on event order.
	task automatic send_word(input item_t it);
		logic rdy;
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {7'd0, it.data_byte, it.record_crc, it.record_size,
			it.record_magic, it.slot};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		predict_word(it);
		if (tx_idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic send_begin(logic slot, logic [31:0] magic, logic [31:0] size,
		logic [31:0] crc);
		item_t it;
		it              = random_word(OP_BEGIN);
		it.slot         = slot;
		it.record_magic = magic;
		it.record_size  = size;
		it.record_crc   = crc;
		send_word(it);
	endtask

	task automatic send_byte(logic [BYTE_W-1:0] b);
		item_t it;
		it           = random_word(OP_BYTE);
		it.data_byte = b;
		send_word(it);
	endtask

	// Random image of the given size under the current magic; stored CRC
	// either matches the bytes or is random.
	task automatic send_image(logic slot, int unsigned size, bit good);
		logic [BYTE_W-1:0] img[$];
		logic [CRC_W-1:0]  c;
		c = CRC_PRESET;
		for (int unsigned i = 0; i < size; i++) begin
			img.push_back(8'($urandom));
			c = crc_fold(c, img[i]);
		end
		send_begin(slot, magic_cfg, size, good ? ~c : $urandom);
		foreach (img[i]) send_byte(img[i]);
	endtask

	// Register write; one cycle with the enable high, then it is lowered.
	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_EXPECTED_MAGIC) begin
			magic_cfg = val;
		end else begin
			limit_cfg = val[LIMIT_W-1:0];
		end
		@(posedge clk);
	endtask

	// Stop offering, wait for every predicted verdict, then let the pipeline
	// run dry in case trailing bytes are still in flight.
	task automatic settle();
		s_tvalid <= 1'b0;
		wait (pending_verdicts.size() == 0);
		@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Reset settings: wrong magic, legacy image, over-limit counts, stray bytes,
	// the standard check string, a bad CRC, and a check abandoned by a begin.
	task automatic test_directed();
		send_begin(1'b0, 32'h0000_0000, 32'd5, 32'h1234_5678);
		send_begin(1'b1, MAGIC_RESET, 32'd0, 32'hFFFF_FFFF);
		// Magic is judged before the zero count.
		send_begin(1'b1, 32'hFFFF_FFFF, 32'd0, 32'h0000_0000);
		send_begin(1'b0, MAGIC_RESET, 32'(LIMIT_RESET) + 32'd1, 32'h0);
		// Low 19 bits are zero here; only a full-width compare catches it.
		send_begin(1'b1, MAGIC_RESET, 32'h8000_0000, 32'h0);
		send_begin(1'b0, MAGIC_RESET, 32'hFFFF_FFFF, 32'h0);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_begin(1'b1, MAGIC_RESET, 32'd9, 32'hCBF4_3926);
		for (int i = 0; i < 9; i++) send_byte(8'h31 + 8'(i));
		send_begin(1'b0, MAGIC_RESET, 32'd1, 32'h0000_0000);
		send_byte(8'h00);
		send_begin(1'b1, MAGIC_RESET, 32'd3, 32'h0);
		send_byte(8'hFF);
		send_begin(1'b0, MAGIC_RESET, 32'd1, 32'hFF00_0000);
		send_byte(8'hFF);
		settle();
	endtask

	// Register extremes: zero magic with zero limit, all-ones magic with the
	// widest limit, and a tiny limit hit exactly and exceeded by one.
	task automatic test_registers();
		write_reg(REG_EXPECTED_MAGIC, 32'h0000_0000);
		write_reg(REG_MAX_IMAGE_BYTES, 32'd0);
		send_begin(1'b0, 32'h0000_0000, 32'd1, 32'h0);
		send_begin(1'b1, 32'h0000_0000, 32'd0, 32'h0);
		send_begin(1'b0, MAGIC_RESET, 32'd0, 32'h0);
		settle();
		write_reg(REG_EXPECTED_MAGIC, 32'hFFFF_FFFF);
		write_reg(REG_MAX_IMAGE_BYTES, 32'h0007_FFFF);
		// Start the widest check, then abandon it with an over-limit begin.
		send_begin(1'b1, 32'hFFFF_FFFF, 32'h0007_FFFF, $urandom);
		send_byte(8'($urandom));
		send_byte(8'($urandom));
		send_begin(1'b0, 32'hFFFF_FFFF, 32'h0008_0000, 32'h0);
		settle();
		write_reg(REG_MAX_IMAGE_BYTES, 32'd4);
		send_image(1'b1, 4, 1'b1);
		send_image(1'b0, 4, 1'b0);
		send_begin(1'b1, 32'hFFFF_FFFF, 32'd5, 32'h0);
		settle();
	endtask

	// Hold the receiver off while begins that answer at once keep coming,
	// so the output side fills up and the input must stall.
	task automatic test_backpressure();
		tx_idling = 1'b0;
		hold_req  = 1'b1;
		repeat (40) send_begin(1'($urandom), magic_cfg, 32'd0, $urandom);
		settle();
	endtask

	// Randomized phases, each under fresh register values. Half the draws are
	// whole images, the rest wrong magic, legacy, over-limit, stray bytes and
	// checks cut short by the next begin.
	task automatic test_random(int unsigned phases, int unsigned per_phase);
		int unsigned done;
		int unsigned size;
		int unsigned cut;
		int unsigned cap;
		logic [31:0] m;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(0, 4))
				0: m = 32'h0000_0000;
				1: m = 32'hFFFF_FFFF;
				default: m = $urandom;
			endcase
			write_reg(REG_EXPECTED_MAGIC, m);
			case ($urandom_range(0, 3))
				0: write_reg(REG_MAX_IMAGE_BYTES, $urandom_range(1, 48));
				1: write_reg(REG_MAX_IMAGE_BYTES, 32'h0007_FFFF);
				2: write_reg(REG_MAX_IMAGE_BYTES, $urandom_range(1, 32'h0007_FFFF));
				default: write_reg(REG_MAX_IMAGE_BYTES, $urandom_range(1, 300));
			endcase
			tx_idling = ($urandom_range(0, 3) != 0);
			rx_idling = ($urandom_range(0, 3) != 0);
			cap  = (limit_cfg < 40) ? limit_cfg : 40;
			done = 0;
			while (done < per_phase) begin
				case ($urandom_range(0, 9))
					0: begin
						do m = $urandom; while (m == magic_cfg);
						send_begin(1'($urandom), m, $urandom, $urandom);
						done++;
					end
					1: begin
						send_begin(1'($urandom), magic_cfg, 32'd0, $urandom);
						done++;
					end
					2: begin
						send_begin(1'($urandom), magic_cfg,
							$urandom_range(32'(limit_cfg) + 1, 32'hFFFF_FFFF), $urandom);
						done++;
					end
					3: begin
						// Dropped by the block when idle; not counted.
						repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
					end
					4: begin
						if (cap >= 2) begin
							size = $urandom_range(2, cap);
							cut  = $urandom_range(1, size - 1);
							send_begin(1'($urandom), magic_cfg, size, $urandom);
							repeat (cut) send_byte(8'($urandom));
							done += 1 + cut;
						end
					end
					default: begin
						size = $urandom_range(1, cap);
						if (limit_cfg <= 256 && $urandom_range(0, 7) == 0) size = limit_cfg;
						send_image(1'($urandom), size, 1'($urandom));
						done += 1 + size;
					end
				endcase
			end
			settle();
		end
	endtask

	// Image exactly as long as the limit allows, with no idling on either side.
	task automatic test_limit_image();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		write_reg(REG_MAX_IMAGE_BYTES, 32'd64);
		send_image(1'($urandom), 64, 1'b1);
		settle();
	endtask

	// Receiver: long hold-off on request, otherwise random stall bursts.
	always begin
		@(posedge clk);
		if (hold_req) begin
			hold_req = 1'b0;
			m_tready <= 1'b0;
			repeat (300) @(posedge clk);
		end else if (rx_idling && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(0, 13)) @(posedge clk);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result checker. Outputs and inputs only move after rising edges, so the
	// falling edge sees exactly what the next rising edge will take.
	result_t got;
	result_t want;
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.verdict      = m_tdata[0];
			got.checked_slot = m_tdata[1];
			got.computed_crc = m_tdata[33:2];
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result word with none expected, actual %h", $time, m_tdata);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (got.verdict != want.verdict) begin
					$display("%0t: verdict mismatch expected %0b actual %0b",
						$time, want.verdict, got.verdict);
					error_count++;
				end
				if (got.checked_slot != want.checked_slot) begin
					$display("%0t: checked_slot mismatch expected %0b actual %0b",
						$time, want.checked_slot, got.checked_slot);
					error_count++;
				end
				if (got.computed_crc != want.computed_crc) begin
					$display("%0t: computed_crc mismatch expected %h actual %h",
						$time, want.computed_crc, got.computed_crc);
					error_count++;
				end
			end
		end
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		m_tready    = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		magic_cfg   = MAGIC_RESET;
		limit_cfg   = LIMIT_RESET;
		crc_acc     = CRC_PRESET;
		bytes_to_go = '0;
		stored_crc  = '0;
		check_open  = 1'b0;
		slot_held   = 1'b0;
		error_count = 0;
		tx_idling   = 1'b1;
		rx_idling   = 1'b1;
		hold_req    = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_registers();
		test_backpressure();
		test_random(6, 230);
		test_limit_image();

		if (pending_verdicts.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_verdicts.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
